@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used across the limiter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("limiter check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("limiter check failed");

`endif

@@ rtl/lpl_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Lookahead peak limiter package
// Field widths, register indexes, reset values and beat types shared by the
// limiter modules.
// ---------------------------------------------------------------------------
package lpl_pkg;

   // Sample word and fixed-point formats
   localparam int SAMPLE_W    = 24;
   localparam int FRAC_BITS   = 24;
   localparam int GAIN_W      = 25;
   localparam int THRESHOLD_W = 23;
   localparam int RELEASE_W   = 24;
   localparam int LENGTH_W    = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   // Remainder width of the reduction divider
   localparam int DIV_W = ((SAMPLE_W > THRESHOLD_W) ? SAMPLE_W : THRESHOLD_W) + 1;

   localparam logic [GAIN_W-1:0] ONE_Q24 = GAIN_W'(1) << FRAC_BITS;

   // Default delay line depth
   localparam int DEF_MAX_LOOKAHEAD = 128;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LENGTH    = 2'd2;

   // Register reset values
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST = 23'd934545;
   localparam logic [RELEASE_W-1:0]   RELEASE_RST   = 24'd16770227;
   localparam logic [LENGTH_W-1:0]    LENGTH_RST    = 8'd96;

   // Input beat: one stereo sample pair
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_left;
      logic signed [SAMPLE_W-1:0] sample_right;
   } req_beat_type;

   // Result beat: delayed, gain-reduced pair and the gain used
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] limited_left;
      logic signed [SAMPLE_W-1:0] limited_right;
      logic [GAIN_W-1:0]          gain_applied;
   } rsp_beat_type;

   // Per-lane control from the sequencer
   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic hit;
      logic clear_peak;
      logic scale_en;
   } lane_ctl_type;

endpackage

@@ rtl/lpl_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module lpl_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 128
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lpl_lane.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Limiter channel lane
// Holds one channel's delay line, scans it for the absolute peak, picks out
// the oldest sample and scales it by the gain with rounding and saturation.
// ---------------------------------------------------------------------------
module lpl_lane #(
   parameter int MAX_LOOKAHEAD = lpl_pkg::DEF_MAX_LOOKAHEAD
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  lpl_pkg::lane_ctl_type                              ctl,
   input  logic [((MAX_LOOKAHEAD > 1) ? $clog2(MAX_LOOKAHEAD) : 1)-1:0] wr_addr,
   input  logic [lpl_pkg::SAMPLE_W-1:0]                       wr_data,
   input  logic [((MAX_LOOKAHEAD > 1) ? $clog2(MAX_LOOKAHEAD) : 1)-1:0] rd_addr,
   input  logic [lpl_pkg::GAIN_W-1:0]                         gain,
   output logic [lpl_pkg::SAMPLE_W-1:0]                       peak,
   output logic [lpl_pkg::SAMPLE_W-1:0]                       result
);

   import lpl_pkg::*;

   localparam int SW     = SAMPLE_W;
   localparam int PROD_W = SW + GAIN_W;
   localparam int RND_W  = PROD_W + 1 - FRAC_BITS;

   localparam logic [PROD_W:0]  HALF_LSB = (PROD_W + 1)'(1) << (FRAC_BITS - 1);
   localparam logic [RND_W-1:0] MAX_POS  = {3'b000, {(SW - 1){1'b1}}};
   localparam logic [RND_W-1:0] MAX_NEG  = {2'b00, 1'b1, {(SW - 1){1'b0}}};
   localparam logic [SW-1:0]    SAT_POS  = {1'b0, {(SW - 1){1'b1}}};
   localparam logic [SW-1:0]    SAT_NEG  = {1'b1, {(SW - 1){1'b0}}};

   logic [SW-1:0]     rd_data;
   logic              rd_valid_ff, rd_valid_in;
   logic              hit_ff, hit_in;
   logic [SW-1:0]     peak_ff, peak_in;
   logic [SW-1:0]     held_ff, held_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [SW-1:0]     rd_mag;
   logic [SW-1:0]     held_mag;
   logic [PROD_W:0]   rnd_sum;
   logic [RND_W-1:0]  rnd_mag;

   // Delay line storage
   lpl_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_LOOKAHEAD)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Read data arrives in the cycle after the address, so the flags follow it.
   assign rd_valid_in = ctl.rd_en;
   assign hit_in      = ctl.hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         hit_ff      <= 1'b0;
      end else begin
         rd_valid_ff <= rd_valid_in;
         hit_ff      <= hit_in;
      end
   end

   // Running absolute peak over the scanned entries.
   assign rd_mag = rd_data[SW-1] ? (SW'(0) - rd_data) : rd_data;

   always_comb begin
      peak_in = peak_ff;
      if (ctl.clear_peak) begin
         peak_in = '0;
      end else if (rd_valid_ff && (rd_mag > peak_ff)) begin
         peak_in = rd_mag;
      end
   end

   // The entry at the read-out position is the delayed sample.
   assign held_in = (rd_valid_ff && hit_ff) ? rd_data : held_ff;

   // Magnitude times gain; the sign is restored after rounding.
   assign held_mag = held_ff[SW-1] ? (SW'(0) - held_ff) : held_ff;
   assign prod_in  = ctl.scale_en ? (held_mag * gain) : prod_ff;

   always_ff @(posedge clock) begin
      peak_ff <= peak_in;
      held_ff <= held_in;
      prod_ff <= prod_in;
   end

   // Round half away from zero on the magnitude, then saturate.
   assign rnd_sum = {1'b0, prod_ff} + HALF_LSB;
   assign rnd_mag = rnd_sum[PROD_W:FRAC_BITS];

   always_comb begin
      if (held_ff[SW-1]) begin
         result = (rnd_mag > MAX_NEG) ? SAT_NEG : (SW'(0) - rnd_mag[SW-1:0]);
      end else begin
         result = (rnd_mag > MAX_POS) ? SAT_POS : rnd_mag[SW-1:0];
      end
   end

   assign peak = peak_ff;

endmodule

@@ rtl/lpl_div.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Reduction divider
// Restoring divider giving floor(threshold * 2^24 / peak), one quotient bit
// per cycle. The caller guarantees threshold is below peak.
// ---------------------------------------------------------------------------
module lpl_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [lpl_pkg::THRESHOLD_W-1:0]  dividend,
   input  logic [lpl_pkg::SAMPLE_W-1:0]     divisor,
   output logic                             done,
   output logic [lpl_pkg::FRAC_BITS-1:0]    quotient
);

   import lpl_pkg::*;

   localparam int CNT_W = $clog2(FRAC_BITS);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(FRAC_BITS - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     dsr_ff, dsr_in;
   logic [FRAC_BITS-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0]     rem_sh;
   logic                 fits;

   // One shift-and-subtract step
   assign rem_sh = {rem_ff[DIV_W-2:0], 1'b0};
   assign fits   = (rem_sh >= dsr_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = DIV_W'(dividend);
         dsr_in  = DIV_W'(divisor);
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? (rem_sh - dsr_ff) : rem_sh;
         quo_in = {quo_ff[FRAC_BITS-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/lookahead_peak_limiter_unit.sv @@
// The input pair is written in idle; both delay RAMs are then scanned in parallel over
// the delay length in use, followed by the read drain, merge, divider (only when the peak
// is above the threshold), envelope, gain, scaling and output states.
// Input is taken only in idle, once the previous result is in the output register.
// Reset: synchronous; a clearing pass zeroes every delay RAM entry first.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// Lookahead peak limiter
// Stereo brickwall limiter: two channel lanes hold the delay lines and find
// their peaks, the merge stage derives reduction, envelope and gain.
// ---------------------------------------------------------------------------
module lookahead_peak_limiter_unit #(
   parameter int MAX_LOOKAHEAD = lpl_pkg::DEF_MAX_LOOKAHEAD
) (
   input  logic                              clock,
   input  logic                              reset,
   // Input beats
   input  logic                              req_valid,
   output logic                              req_stall,
   input  lpl_pkg::req_beat_type             req_beat,
   // Result beats
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output lpl_pkg::rsp_beat_type             rsp_beat,
   // Configuration writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lpl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lpl_pkg::CSR_DATA_W-1:0]    csr_data
);

   import lpl_pkg::*;

   localparam int AW = (MAX_LOOKAHEAD > 1) ? $clog2(MAX_LOOKAHEAD) : 1;
   localparam int CW = $clog2(MAX_LOOKAHEAD + 1);
   localparam int SW = SAMPLE_W;
   localparam int EP_W = GAIN_W + RELEASE_W;

   localparam logic [CW-1:0] CLR_LAST = CW'(MAX_LOOKAHEAD - 1);

   typedef enum logic [9:0] {
      ST_CLEAR = 10'b0000000001,
      ST_IDLE  = 10'b0000000010,
      ST_SCAN  = 10'b0000000100,
      ST_DRAIN = 10'b0000001000,
      ST_MERGE = 10'b0000010000,
      ST_DIV   = 10'b0000100000,
      ST_ENV   = 10'b0001000000,
      ST_GAIN  = 10'b0010000000,
      ST_SCALE = 10'b0100000000,
      ST_OUT   = 10'b1000000000
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         clr_cnt_ff, clr_cnt_in;
   logic [THRESHOLD_W-1:0] threshold_ff, threshold_in;
   logic [RELEASE_W-1:0]  release_ff, release_in;
   logic [LENGTH_W-1:0]   length_ff, length_in;
   logic [AW-1:0]         wp_ff, wp_in;
   logic [AW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]         len_ff, len_in;
   logic [CW-1:0]         scan_cnt_ff, scan_cnt_in;
   logic [GAIN_W-1:0]     reduction_ff, reduction_in;
   logic [GAIN_W-1:0]     decay_ff, decay_in;
   logic [GAIN_W-1:0]     env_ff, env_in;
   logic [GAIN_W-1:0]     gain_ff, gain_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_beat_type          rsp_beat_ff, rsp_beat_in;

   logic                  req_take;
   logic                  rsp_take;
   logic                  out_load;
   logic [LENGTH_W-1:0]   len_nz;
   logic [31:0]           len_sel;
   logic [CW-1:0]         wp_use;
   logic [CW-1:0]         wp_inc;
   logic [CW-1:0]         rd_next;
   logic                  scan_last;
   lane_ctl_type          lane_ctl;
   logic [AW-1:0]         wr_addr;
   logic [SW-1:0]         wr_left, wr_right;
   logic [SW-1:0]         peak_l, peak_r, peak_max;
   logic [SW-1:0]         res_l, res_r;
   logic                  over;
   logic                  div_start;
   logic                  div_done;
   logic [FRAC_BITS-1:0]  div_quo;
   logic [EP_W-1:0]       env_prod;
   logic [GAIN_W-1:0]     env_max;

   // Handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;

   // Configuration registers
   always_comb begin
      threshold_in = threshold_ff;
      release_in   = release_ff;
      length_in    = length_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_THRESHOLD: threshold_in = csr_data[THRESHOLD_W-1:0];
            CSR_RELEASE:   release_in   = csr_data[RELEASE_W-1:0];
            CSR_LENGTH:    length_in    = csr_data[LENGTH_W-1:0];
            default:       ;
         endcase
      end
   end

   // Effective length: zero acts as one, and it never exceeds the RAM depth.
   assign len_nz  = (length_ff == '0) ? LENGTH_W'(1) : length_ff;
   assign len_sel = (32'(len_nz) > 32'(MAX_LOOKAHEAD)) ? 32'(MAX_LOOKAHEAD)
                                                       : 32'(len_nz);

   // Write position restarts at zero when the length has been lowered.
   assign wp_use  = (CW'(wp_ff) >= len_sel[CW-1:0]) ? '0 : CW'(wp_ff);
   assign wp_inc  = wp_use + CW'(1);
   assign rd_next = (wp_inc >= len_sel[CW-1:0]) ? '0 : wp_inc;

   assign scan_last = (scan_cnt_ff == (len_ff - CW'(1)));

   // Lane control and write port selection
   always_comb begin
      lane_ctl.wr_en      = (state_ff == ST_CLEAR) || req_take;
      lane_ctl.rd_en      = (state_ff == ST_SCAN);
      lane_ctl.hit        = (state_ff == ST_SCAN) && (scan_cnt_ff == CW'(rd_ptr_ff));
      lane_ctl.clear_peak = req_take;
      lane_ctl.scale_en   = (state_ff == ST_SCALE);
   end

   assign wr_addr  = (state_ff == ST_CLEAR) ? clr_cnt_ff[AW-1:0] : wp_use[AW-1:0];
   assign wr_left  = (state_ff == ST_CLEAR) ? '0 : req_beat.sample_left;
   assign wr_right = (state_ff == ST_CLEAR) ? '0 : req_beat.sample_right;

   // Left and right lanes work side by side
   lpl_lane #(
      .MAX_LOOKAHEAD (MAX_LOOKAHEAD)
   ) u_lane_left (
      .clock   (clock),
      .reset   (reset),
      .ctl     (lane_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_left),
      .rd_addr (scan_cnt_ff[AW-1:0]),
      .gain    (gain_ff),
      .peak    (peak_l),
      .result  (res_l)
   );

   lpl_lane #(
      .MAX_LOOKAHEAD (MAX_LOOKAHEAD)
   ) u_lane_right (
      .clock   (clock),
      .reset   (reset),
      .ctl     (lane_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_right),
      .rd_addr (scan_cnt_ff[AW-1:0]),
      .gain    (gain_ff),
      .peak    (peak_r),
      .result  (res_r)
   );

   // Merge the lane peaks and start the divider when above threshold.
   assign peak_max  = (peak_l > peak_r) ? peak_l : peak_r;
   assign over      = (DIV_W'(peak_max) > DIV_W'(threshold_ff));
   assign div_start = (state_ff == ST_MERGE) && over;

   lpl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (threshold_ff),
      .divisor  (peak_max),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Envelope decay and update
   assign env_prod = env_ff * release_ff;
   assign env_max  = (decay_ff > reduction_ff) ? decay_ff : reduction_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      wp_in        = wp_ff;
      rd_ptr_in    = rd_ptr_ff;
      len_in       = len_ff;
      scan_cnt_in  = scan_cnt_ff;
      reduction_in = reduction_ff;
      decay_in     = decay_ff;
      env_in       = env_ff;
      gain_in      = gain_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + CW'(1);
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               len_in      = len_sel[CW-1:0];
               wp_in       = rd_next[AW-1:0];
               rd_ptr_in   = rd_next[AW-1:0];
               scan_cnt_in = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            scan_cnt_in = scan_cnt_ff + CW'(1);
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            reduction_in = '0;
            state_in     = over ? ST_DIV : ST_ENV;
         end
         ST_DIV: begin
            if (div_done) begin
               reduction_in = ONE_Q24 - GAIN_W'(div_quo);
               state_in     = ST_ENV;
            end
         end
         ST_ENV: begin
            decay_in = env_prod[EP_W-1:FRAC_BITS];
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            env_in   = (env_max > ONE_Q24) ? ONE_Q24 : env_max;
            gain_in  = ONE_Q24 - ((env_max > ONE_Q24) ? ONE_Q24 : env_max);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_beat_in  = rsp_beat_ff;
      if (out_load) begin
         rsp_valid_in               = 1'b1;
         rsp_beat_in.limited_left  = res_l;
         rsp_beat_in.limited_right = res_r;
         rsp_beat_in.gain_applied  = gain_ff;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         threshold_ff <= THRESHOLD_RST;
         release_ff   <= RELEASE_RST;
         length_ff    <= LENGTH_RST;
         wp_ff        <= '0;
         rd_ptr_ff    <= '0;
         len_ff       <= CW'(1);
         scan_cnt_ff  <= '0;
         env_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         threshold_ff <= threshold_in;
         release_ff   <= release_in;
         length_ff    <= length_in;
         wp_ff        <= wp_in;
         rd_ptr_ff    <= rd_ptr_in;
         len_ff       <= len_in;
         scan_cnt_ff  <= scan_cnt_in;
         env_ff       <= env_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      reduction_ff <= reduction_in;
      decay_ff     <= decay_in;
      gain_ff      <= gain_in;
      rsp_beat_ff  <= rsp_beat_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

   // Checks
   `ASSERT_IMPLY(a_env_in_range, clock, reset, 1'b1, env_ff <= ONE_Q24)
   `ASSERT_IMPLY(a_div_done_in_div, clock, reset, div_done, state_ff == ST_DIV)
   `ASSERT_IMPLY(a_scan_in_len, clock, reset, state_ff == ST_SCAN, scan_cnt_ff < len_ff)
   `ASSERT_NEXT(a_out_loaded, clock, reset, out_load, rsp_valid_ff && (state_ff == ST_IDLE))

endmodule

@@ tb/sv/limiter_check.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Limiter result checker
// Watches the configuration, input and result channels of the lookahead peak
// limiter. It keeps its own copy of the delay lines, write position, gain
// envelope and registers, works out the limited pair for every accepted
// input beat and compares each accepted result beat, field by field, with
// the oldest pair still waiting.
// ---------------------------------------------------------------------------
module limiter_check #(
   parameter int MAX_LOOKAHEAD = lpl_pkg::DEF_MAX_LOOKAHEAD
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  lpl_pkg::req_beat_type             req_beat,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  lpl_pkg::rsp_beat_type             rsp_beat,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [lpl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lpl_pkg::CSR_DATA_W-1:0]    csr_data,
   output int                                fail_count,
   output int                                pending
);
   import lpl_pkg::*;

   localparam longint unsigned SAMPLE_MAX = (64'd1 << (SAMPLE_W - 1)) - 1;

   // Shadow copy of the block state and its registers.
   logic signed [SAMPLE_W-1:0] line_left  [MAX_LOOKAHEAD];
   logic signed [SAMPLE_W-1:0] line_right [MAX_LOOKAHEAD];
   int unsigned                write_pos;
   logic [GAIN_W-1:0]          envelope;
   logic [THRESHOLD_W-1:0]     threshold;
   logic [RELEASE_W-1:0]       release_coef;
   logic [LENGTH_W-1:0]        length_reg;

   rsp_beat_type expected_pairs [$];
   int           errors;

   function automatic longint unsigned magnitude(logic signed [SAMPLE_W-1:0] s);
      longint v;
      v = s;
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   // Scales one delayed sample by the gain, rounding ties away from zero and
   // saturating to the sample range.
   function automatic logic signed [SAMPLE_W-1:0] apply_gain(
      logic signed [SAMPLE_W-1:0] s, logic [GAIN_W-1:0] gain);
      longint unsigned r;
      r = (magnitude(s) * 64'(gain) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (s < 0) begin
         if (r > SAMPLE_MAX + 1)
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
         return SAMPLE_W'(-longint'(r));
      end
      if (r > SAMPLE_MAX)
         return SAMPLE_W'(SAMPLE_MAX);
      return SAMPLE_W'(r);
   endfunction

   // Stores one pair, reads out the oldest one and updates the envelope from
   // the peak over both lines.
   function automatic rsp_beat_type limit_pair(req_beat_type pair);
      int unsigned     span;
      int unsigned     rd;
      longint unsigned peak;
      longint unsigned reduction;
      longint unsigned decayed;
      longint unsigned env;
      longint unsigned gain;
      rsp_beat_type    res;
      // A length of zero acts as one; a length above the depth acts as the depth.
      span = (length_reg == 0) ? 1 :
             ((length_reg > MAX_LOOKAHEAD) ? MAX_LOOKAHEAD : length_reg);
      // The position restarts when the length has been lowered below it.
      if (write_pos >= span)
         write_pos = 0;
      line_left[write_pos]  = pair.sample_left;
      line_right[write_pos] = pair.sample_right;
      rd = write_pos + 1;
      if (rd >= span)
         rd = 0;

      // Entries beyond the length in use are ignored by the peak search.
      peak = 0;
      for (int i = 0; i < span; i++) begin
         if (magnitude(line_left[i]) > peak)
            peak = magnitude(line_left[i]);
         if (magnitude(line_right[i]) > peak)
            peak = magnitude(line_right[i]);
      end

      reduction = 0;
      if (peak > threshold)
         reduction = 64'(ONE_Q24) - ((64'(threshold) << FRAC_BITS) / peak);
      decayed = (64'(envelope) * 64'(release_coef)) >> FRAC_BITS;
      env = (decayed > reduction) ? decayed : reduction;
      if (env > 64'(ONE_Q24))
         env = 64'(ONE_Q24);
      envelope = GAIN_W'(env);
      gain = 64'(ONE_Q24) - env;

      res.limited_left  = apply_gain(line_left[rd], GAIN_W'(gain));
      res.limited_right = apply_gain(line_right[rd], GAIN_W'(gain));
      res.gain_applied  = GAIN_W'(gain);
      write_pos = rd;
      return res;
   endfunction

   // Channel monitor: register writes, result comparison and prediction.
   always @(posedge clock) begin
      rsp_beat_type want;
      if (reset) begin
         for (int i = 0; i < MAX_LOOKAHEAD; i++) begin
            line_left[i]  = '0;
            line_right[i] = '0;
         end
         write_pos    = 0;
         envelope     = '0;
         threshold    = THRESHOLD_RST;
         release_coef = RELEASE_RST;
         length_reg   = LENGTH_RST;
         expected_pairs.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_THRESHOLD: threshold    = csr_data[THRESHOLD_W-1:0];
               CSR_RELEASE:   release_coef = csr_data[RELEASE_W-1:0];
               CSR_LENGTH:    length_reg   = csr_data[LENGTH_W-1:0];
               default: ;
            endcase
         end

         // A result beat can only belong to an input beat taken earlier.
         if (rsp_valid && !rsp_stall) begin
            if (expected_pairs.size() == 0) begin
               $error("result beat with no expected pair waiting");
               errors++;
            end else begin
               want = expected_pairs.pop_front();
               if (rsp_beat.limited_left !== want.limited_left) begin
                  $error("limited_left: expected %0d, got %0d",
                         want.limited_left, rsp_beat.limited_left);
                  errors++;
               end
               if (rsp_beat.limited_right !== want.limited_right) begin
                  $error("limited_right: expected %0d, got %0d",
                         want.limited_right, rsp_beat.limited_right);
                  errors++;
               end
               if (rsp_beat.gain_applied !== want.gain_applied) begin
                  $error("gain_applied: expected %0d, got %0d",
                         want.gain_applied, rsp_beat.gain_applied);
                  errors++;
               end
            end
         end

         // Each accepted input beat queues its predicted result at the tail.
         if (req_valid && !req_stall)
            expected_pairs.insert(expected_pairs.size(), limit_pair(req_beat));
      end
      fail_count <= errors;
      pending    <= expected_pairs.size();
   end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Lookahead peak limiter testbench
// Drives directed pairs at the sample extremes and for each special length
// and threshold setting, then phases of random pairs under random register
// settings, with random idling on both channels, one long result hold-off
// and one phase without idling. A separate checker predicts and compares.
// ---------------------------------------------------------------------------
module tb_top;
   import lpl_pkg::*;

   localparam int MAX_LOOKAHEAD  = DEF_MAX_LOOKAHEAD;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 400;
   localparam int RANDOM_ITEMS   = 1075;
   localparam logic signed [SAMPLE_W-1:0] PEAK_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] PEAK_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_beat_type            req_beat  = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_beat_type            rsp_beat;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index = CSR_THRESHOLD;
   logic [CSR_DATA_W-1:0]   csr_data  = '0;

   int          fail_count;
   int          pending;
   int          idle_cycles = 0;
   int          hold_left   = 0;
   logic        hold_req    = 1'b0;
   logic        hold_done   = 1'b0;
   logic        quiet       = 1'b0;
   int unsigned level       = 32'(THRESHOLD_RST);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   lookahead_peak_limiter_unit #(.MAX_LOOKAHEAD(MAX_LOOKAHEAD)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   limiter_check #(.MAX_LOOKAHEAD(MAX_LOOKAHEAD)) pair_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_beat   (req_beat),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_beat   (rsp_beat),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Result side: one long hold-off on request, no stalls in the quiet phase, otherwise random stalls.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 23);
      end
   end

   // Watchdog: ends the run when no beat of any kind has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Waits until every expected result beat has come back.
   task automatic drain();
      do
         @(posedge clock);
      while (pending != 0);
   endtask

   // Writes all three registers while the block is idle.
   task automatic set_registers(logic [CSR_DATA_W-1:0] thr,
                                logic [CSR_DATA_W-1:0] rel,
                                logic [CSR_DATA_W-1:0] len);
      logic [CSR_INDEX_W-1:0] idx  [3];
      logic [CSR_DATA_W-1:0]  vals [3];
      idx  = '{CSR_THRESHOLD, CSR_RELEASE, CSR_LENGTH};
      vals = '{thr, rel, len};
      drain();
      for (int k = 0; k < 3; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data  <= vals[k];
         do
            @(posedge clock);
         while (!csr_ready);
      end
      csr_valid <= 1'b0;
      level = 32'(thr[THRESHOLD_W-1:0]);
   endtask

   // Offers one input beat after a random gap and waits until it is taken.
   task automatic send_pair(logic signed [SAMPLE_W-1:0] left,
                            logic signed [SAMPLE_W-1:0] right);
      req_beat_type pair;
      while (!quiet && $urandom_range(0, 99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      pair.sample_left  = left;
      pair.sample_right = right;
      req_valid <= 1'b1;
      req_beat  <= pair;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   // Random sample: loud, near the threshold, quiet or at an extreme.
   function automatic logic signed [SAMPLE_W-1:0] pick_sample(int unsigned thr);
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2, 9: return SAMPLE_W'($urandom);
         3, 4, 5: begin
            v = int'(thr) + int'($urandom_range(0, 8192)) - 4096;
            if (v < 0)
               v = 0;
            if (v > int'(PEAK_POS))
               v = int'(PEAK_POS);
            return $urandom_range(0, 1) ? SAMPLE_W'(-v) : SAMPLE_W'(v);
         end
         6, 7: return SAMPLE_W'(int'($urandom_range(0, 8191)) - 4096);
         default: begin
            case ($urandom_range(0, 4))
               0: return PEAK_POS;
               1: return PEAK_NEG;
               2: return -1;
               3: return 1;
               default: return 0;
            endcase
         end
      endcase
   endfunction

   initial begin
      int unsigned random_items;
      int unsigned phase_no;
      int unsigned count;
      int unsigned span;
      logic [CSR_DATA_W-1:0] thr;
      logic [CSR_DATA_W-1:0] rel;
      logic [CSR_DATA_W-1:0] len;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Register defaults: extremes of both sample fields around the threshold.
      send_pair(PEAK_POS, PEAK_POS);
      send_pair(PEAK_NEG, PEAK_NEG);
      send_pair(PEAK_POS, PEAK_NEG);
      send_pair(0, 0);
      send_pair(-1, 1);
      send_pair(SAMPLE_W'(THRESHOLD_RST), -SAMPLE_W'(THRESHOLD_RST));
      send_pair(SAMPLE_W'(THRESHOLD_RST) + SAMPLE_W'(1), 0);
      send_pair(0, -(SAMPLE_W'(THRESHOLD_RST) + SAMPLE_W'(1)));
      req_valid <= 1'b0;

      // Threshold zero with length one: any nonzero peak removes all gain.
      set_registers(0, 0, 1);
      send_pair(0, 0);
      send_pair(5, -5);
      send_pair(PEAK_POS, PEAK_NEG);
      send_pair(1, 0);
      req_valid <= 1'b0;

      // Length zero acts as one; top threshold bit is masked off.
      set_registers(24'hFFFFFF, 24'hFFFFFF, 0);
      send_pair(PEAK_NEG, PEAK_POS);
      send_pair(100, -100);
      send_pair(0, 0);
      req_valid <= 1'b0;

      // Length above the depth acts as the full depth.
      set_registers(1, 24'hFFFFFF, 255);
      send_pair(PEAK_POS, 0);
      send_pair(0, PEAK_NEG);
      send_pair(12345, -54321);
      send_pair(2, -2);
      req_valid <= 1'b0;

      // Lowering the length below the write position restarts it, and the
      // entries beyond the length come back once it is raised again.
      set_registers(CSR_DATA_W'(THRESHOLD_RST), CSR_DATA_W'(RELEASE_RST), 2);
      send_pair(PEAK_NEG, PEAK_NEG);
      send_pair(3, 3);
      req_valid <= 1'b0;
      set_registers(CSR_DATA_W'(THRESHOLD_RST), CSR_DATA_W'(RELEASE_RST),
                    CSR_DATA_W'(MAX_LOOKAHEAD));
      send_pair(0, 0);
      send_pair(1, 1);
      req_valid <= 1'b0;

      // Random phases, mostly short delay lines.
      random_items = 0;
      phase_no     = 0;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0:       thr = 1;
            1:       thr = PEAK_POS;
            2:       thr = CSR_DATA_W'($urandom_range(1, 1 << 16));
            default: thr = CSR_DATA_W'($urandom_range(1 << 18, 1 << 22));
         endcase
         thr[CSR_DATA_W-1] = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 3))
            0:       rel = 0;
            1:       rel = 24'hFFFFFF;
            2:       rel = CSR_DATA_W'(32'hFFFFFF - $urandom_range(0, 1 << 16));
            default: rel = CSR_DATA_W'($urandom);
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: len = CSR_DATA_W'($urandom_range(1, 8));
            6, 7:             len = CSR_DATA_W'($urandom_range(9, 40));
            8:                len = CSR_DATA_W'($urandom_range(96, MAX_LOOKAHEAD));
            default:          len = $urandom_range(0, 1) ? CSR_DATA_W'(0)
                                                         : CSR_DATA_W'($urandom_range(129, 255));
         endcase
         span  = (len == 0) ? 1 : ((len > MAX_LOOKAHEAD) ? MAX_LOOKAHEAD : 32'(len));
         count = (span > 40) ? 25 : 110;

         set_registers(thr, rel, len);
         // One phase holds the result side off; another runs without gaps.
         if (phase_no == 2)
            hold_req <= 1'b1;
         quiet <= (phase_no == 4);
         for (int n = 0; n < count; n++)
            send_pair(pick_sample(level), pick_sample(level));
         req_valid <= 1'b0;
         random_items += count;
         phase_no++;
      end

      drain();
      repeat (MAX_LOOKAHEAD + 64) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
